### hdl/mfw_pkg.sv
// Package for the recursive mutex with FIFO wait queue.
// Holds sizing constants, shared types and helper functions; no dependencies.
package mfw_pkg;

  localparam int THREAD_COUNT = 16;
  localparam int NEST_BITS    = 8;
  localparam int TID_W        = $clog2(THREAD_COUNT);
  localparam int CNT_W        = $clog2(THREAD_COUNT + 1);
  localparam int IN_TID_W     = 4;
  localparam int OUT_TID_W    = 4;
  localparam int STATUS_W     = 4;
  localparam int DEPTH_W      = 8;

  typedef logic [TID_W-1:0]     tid_t;
  typedef logic [NEST_BITS-1:0] nest_t;

  typedef enum logic {
    OP_ACQUIRE = 1'b0,
    OP_RELEASE = 1'b1
  } op_t;

  typedef enum logic [STATUS_W-1:0] {
    ST_GRANTED         = 4'd0,
    ST_NESTED          = 4'd1,
    ST_BLOCKED         = 4'd2,
    ST_UNNESTED        = 4'd3,
    ST_FREED           = 4'd4,
    ST_HANDOFF         = 4'd5,
    ST_NOT_HOLDER      = 4'd6,
    ST_ALREADY_WAITING = 4'd7,
    ST_OVERFLOW        = 4'd8
  } status_t;

  // queue command from lock core
  typedef struct packed {
    logic push;
    logic pop;
    tid_t push_tid;
    tid_t query_tid;
  } q_cmd_t;

  // queue status to lock core
  typedef struct packed {
    logic empty;
    logic full;
    tid_t head_tid;
    logic query_waiting;
  } q_stat_t;

  typedef struct packed {
    status_t              status;
    logic                 woken_valid;
    logic [OUT_TID_W-1:0] woken_thread;
    logic                 holder_valid;
    logic [OUT_TID_W-1:0] holder_thread;
    logic [DEPTH_W-1:0]   nest_depth;
  } result_t;

  function automatic tid_t wrap_tid(input logic [IN_TID_W-1:0] raw);
    return TID_W'(raw % THREAD_COUNT);
  endfunction

  function automatic logic [DEPTH_W-1:0] sat_depth(input nest_t n);
    logic [NEST_BITS+DEPTH_W-1:0] wide;
    wide = (NEST_BITS + DEPTH_W)'(n);
    if (wide > (NEST_BITS + DEPTH_W)'({DEPTH_W{1'b1}})) begin
      return {DEPTH_W{1'b1}};
    end
    return DEPTH_W'(wide);
  endfunction

endpackage

### hdl/mfw_wait_queue.sv
// Circular queue of blocked thread IDs plus per-thread waiting flags.
// Depends on mfw_pkg.
module mfw_wait_queue import mfw_pkg::*; (
  input  logic    clk,
  input  logic    rst_n,
  input  q_cmd_t  cmd,
  output q_stat_t stat
);

  tid_t              slot_r [THREAD_COUNT];
  tid_t              head_r, head_nxt;
  tid_t              tail_r, tail_nxt;
  logic [CNT_W-1:0]  count_r, count_nxt;
  logic [THREAD_COUNT-1:0] waiting_r, waiting_nxt;

  function automatic tid_t ptr_inc(input tid_t p);
    return (p == TID_W'(THREAD_COUNT - 1)) ? '0 : p + TID_W'(1);
  endfunction

  always_comb begin
    head_nxt    = head_r;
    tail_nxt    = tail_r;
    count_nxt   = count_r;
    waiting_nxt = waiting_r;
    if (cmd.push) begin
      tail_nxt                  = ptr_inc(tail_r);
      waiting_nxt[cmd.push_tid] = 1'b1;
    end
    if (cmd.pop) begin
      head_nxt                      = ptr_inc(head_r);
      waiting_nxt[slot_r[head_r]]   = 1'b0;
    end
    if (cmd.push && !cmd.pop) begin
      count_nxt = count_r + CNT_W'(1);
    end else if (cmd.pop && !cmd.push) begin
      count_nxt = count_r - CNT_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      head_r    <= '0;
      tail_r    <= '0;
      count_r   <= '0;
      waiting_r <= '0;
    end else begin
      head_r    <= head_nxt;
      tail_r    <= tail_nxt;
      count_r   <= count_nxt;
      waiting_r <= waiting_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.push) begin
      slot_r[tail_r] <= cmd.push_tid;
    end
  end

  assign stat.empty         = (count_r == '0);
  assign stat.full          = (count_r >= CNT_W'(THREAD_COUNT));
  assign stat.head_tid      = slot_r[head_r];
  assign stat.query_waiting = waiting_r[cmd.query_tid];

endmodule

### hdl/mfw_lock_core.sv
// Lock ownership state and request decision logic; drives the wait queue.
// Depends on mfw_pkg and mfw_wait_queue.
module mfw_lock_core import mfw_pkg::*; (
  input  logic    clk,
  input  logic    rst_n,
  input  logic    advance,
  input  op_t     op,
  input  tid_t    tid,
  output result_t result
);

  logic    owned_r, owned_nxt;
  tid_t    owner_r, owner_nxt;
  nest_t   nest_r, nest_nxt;
  q_cmd_t  q_cmd;
  q_stat_t q_stat;
  status_t status;
  logic    woken_v;
  tid_t    woken_t;

  mfw_wait_queue u_queue (
    .clk  (clk),
    .rst_n(rst_n),
    .cmd  (q_cmd),
    .stat (q_stat)
  );

  always_comb begin
    owned_nxt       = owned_r;
    owner_nxt       = owner_r;
    nest_nxt        = nest_r;
    q_cmd.push      = 1'b0;
    q_cmd.pop       = 1'b0;
    q_cmd.push_tid  = tid;
    q_cmd.query_tid = tid;
    woken_v         = 1'b0;
    woken_t         = '0;
    status          = ST_NOT_HOLDER;
    case (op)
      OP_ACQUIRE: begin
        if (!owned_r) begin
          owned_nxt = 1'b1;
          owner_nxt = tid;
          nest_nxt  = NEST_BITS'(1);
          status    = ST_GRANTED;
        end else if (owner_r == tid) begin
          if (nest_r == {NEST_BITS{1'b1}}) begin
            status = ST_OVERFLOW;
          end else begin
            nest_nxt = nest_r + NEST_BITS'(1);
            status   = ST_NESTED;
          end
        end else if (q_stat.query_waiting || q_stat.full) begin
          status = ST_ALREADY_WAITING;
        end else begin
          q_cmd.push = advance;
          status     = ST_BLOCKED;
        end
      end
      OP_RELEASE: begin
        if (!owned_r || owner_r != tid) begin
          status = ST_NOT_HOLDER;
        end else if (nest_r > NEST_BITS'(1)) begin
          nest_nxt = nest_r - NEST_BITS'(1);
          status   = ST_UNNESTED;
        end else if (!q_stat.empty) begin
          q_cmd.pop = advance;
          owner_nxt = q_stat.head_tid;
          nest_nxt  = NEST_BITS'(1);
          woken_v   = 1'b1;
          woken_t   = q_stat.head_tid;
          status    = ST_HANDOFF;
        end else begin
          owned_nxt = 1'b0;
          owner_nxt = '0;
          nest_nxt  = '0;
          status    = ST_FREED;
        end
      end
      default: status = ST_NOT_HOLDER;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      owned_r <= 1'b0;
      owner_r <= '0;
      nest_r  <= '0;
    end else if (advance) begin
      owned_r <= owned_nxt;
      owner_r <= owner_nxt;
      nest_r  <= nest_nxt;
    end
  end

  assign result.status        = status;
  assign result.woken_valid   = woken_v;
  assign result.woken_thread  = OUT_TID_W'(woken_t);
  assign result.holder_valid  = owned_nxt;
  assign result.holder_thread = owned_nxt ? OUT_TID_W'(owner_nxt) : '0;
  assign result.nest_depth    = owned_nxt ? sat_depth(nest_nxt) : '0;

endmodule

### hdl/recursive_mutex_fifo_waiters.sv
// Recursive mutex with FIFO wait queue: input register, lock core, result register.
// A request is captured in the input register, decided by the lock core and captured
// in the result register; throughput 1 request/cycle while the result is not stalled.
// Input stalls only while a registered request waits behind a stalled result.
// Synchronous active-low reset frees the lock, empties the queue and clears all waiting
// flags; queue slots are not cleared and are only read after being written.
// Depends on mfw_pkg, mfw_lock_core, mfw_wait_queue.
module recursive_mutex_fifo_waiters import mfw_pkg::*; (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_valid,
  output logic                 in_stall,
  input  logic                 in_operation,
  input  logic [IN_TID_W-1:0]  in_thread_id,
  output logic                 out_valid,
  input  logic                 out_stall,
  output logic [STATUS_W-1:0]  out_status,
  output logic                 out_woken_valid,
  output logic [OUT_TID_W-1:0] out_woken_thread,
  output logic                 out_holder_valid,
  output logic [OUT_TID_W-1:0] out_holder_thread,
  output logic [DEPTH_W-1:0]   out_nest_depth
);

  logic    in_vld_r;
  op_t     in_op_r;
  tid_t    in_tid_r;
  logic    out_vld_r;
  result_t res_r;
  result_t res;
  logic    advance;

  assign advance  = in_vld_r && (!out_vld_r || !out_stall);
  assign in_stall = in_vld_r && !advance;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_vld_r <= 1'b0;
    end else if (!in_stall) begin
      in_vld_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (!in_stall && in_valid) begin
      in_op_r  <= op_t'(in_operation);
      in_tid_r <= wrap_tid(in_thread_id);
    end
  end

  mfw_lock_core u_core (
    .clk    (clk),
    .rst_n  (rst_n),
    .advance(advance),
    .op     (in_op_r),
    .tid    (in_tid_r),
    .result (res)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_vld_r <= 1'b0;
    end else if (advance) begin
      out_vld_r <= 1'b1;
    end else if (!out_stall) begin
      out_vld_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      res_r <= res;
    end
  end

  assign out_valid         = out_vld_r;
  assign out_status        = res_r.status;
  assign out_woken_valid   = res_r.woken_valid;
  assign out_woken_thread  = res_r.woken_thread;
  assign out_holder_valid  = res_r.holder_valid;
  assign out_holder_thread = res_r.holder_thread;
  assign out_nest_depth    = res_r.nest_depth;

endmodule

### bench/tb.sv
// Testbench for recursive_mutex_fifo_waiters: directed and random acquire/release traffic,
// each result checked against an in-bench lock and wait-queue predictor.
// Depends on mfw_pkg and the recursive_mutex_fifo_waiters RTL.
`timescale 1ns / 1ps

module tb;
  import mfw_pkg::*;

  localparam int CYCLE_LIMIT = 200000;
  localparam int DRAIN_CYCLES = 8;

  logic                 clk = 1'b0;
  logic                 rst_n;
  logic                 in_valid;
  logic                 in_stall;
  logic                 in_operation;
  logic [IN_TID_W-1:0]  in_thread_id;
  logic                 out_valid;
  logic                 out_stall;
  logic [STATUS_W-1:0]  out_status;
  logic                 out_woken_valid;
  logic [OUT_TID_W-1:0] out_woken_thread;
  logic                 out_holder_valid;
  logic [OUT_TID_W-1:0] out_holder_thread;
  logic [DEPTH_W-1:0]   out_nest_depth;

  // lock state mirror
  bit      lock_owned;
  tid_t    lock_owner;
  nest_t   lock_depth;
  tid_t    wait_ring [THREAD_COUNT];
  int      ring_head;
  int      ring_tail;
  int      ring_count;
  bit      is_queued [THREAD_COUNT];

  result_t pending_results [$];
  int      error_count;
  int      cycle_count;
  bit      calm_tail;

  recursive_mutex_fifo_waiters i_dut (
    .clk              (clk),
    .rst_n            (rst_n),
    .in_valid         (in_valid),
    .in_stall         (in_stall),
    .in_operation     (in_operation),
    .in_thread_id     (in_thread_id),
    .out_valid        (out_valid),
    .out_stall        (out_stall),
    .out_status       (out_status),
    .out_woken_valid  (out_woken_valid),
    .out_woken_thread (out_woken_thread),
    .out_holder_valid (out_holder_valid),
    .out_holder_thread(out_holder_thread),
    .out_nest_depth   (out_nest_depth)
  );

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("tb: failure");
      $finish;
    end
  end

  function automatic result_t predict_lock(input op_t op, input logic [IN_TID_W-1:0] raw_tid);
    result_t r;
    tid_t    tid;
    tid_t    next_tid;
    r = '0;
    tid = tid_t'(raw_tid % THREAD_COUNT);
    if (op == OP_ACQUIRE) begin
      if (!lock_owned) begin
        lock_owned = 1'b1;
        lock_owner = tid;
        lock_depth = NEST_BITS'(1);
        r.status = ST_GRANTED;
      end else if (lock_owner == tid) begin
        if (lock_depth == {NEST_BITS{1'b1}}) begin
          r.status = ST_OVERFLOW;
        end else begin
          lock_depth = lock_depth + 1'b1;
          r.status = ST_NESTED;
        end
      end else if (is_queued[tid] || ring_count >= THREAD_COUNT) begin
        r.status = ST_ALREADY_WAITING;
      end else begin
        wait_ring[ring_tail] = tid;
        ring_tail = (ring_tail + 1) % THREAD_COUNT;
        ring_count++;
        is_queued[tid] = 1'b1;
        r.status = ST_BLOCKED;
      end
    end else begin
      if (!lock_owned || lock_owner != tid) begin
        r.status = ST_NOT_HOLDER;
      end else if (lock_depth > 1) begin
        lock_depth = lock_depth - 1'b1;
        r.status = ST_UNNESTED;
      end else if (ring_count > 0) begin
        next_tid = wait_ring[ring_head];
        ring_head = (ring_head + 1) % THREAD_COUNT;
        ring_count--;
        is_queued[next_tid] = 1'b0;
        lock_owner = next_tid;
        lock_depth = NEST_BITS'(1);
        r.woken_valid = 1'b1;
        r.woken_thread = next_tid;
        r.status = ST_HANDOFF;
      end else begin
        lock_owned = 1'b0;
        lock_owner = '0;
        lock_depth = '0;
        r.status = ST_FREED;
      end
    end
    r.holder_valid = lock_owned;
    r.holder_thread = lock_owned ? lock_owner : '0;
    if (!lock_owned) begin
      r.nest_depth = '0;
    end else if (lock_depth > 2 ** DEPTH_W - 1) begin
      r.nest_depth = {DEPTH_W{1'b1}};
    end else begin
      r.nest_depth = DEPTH_W'(lock_depth);
    end
    return r;
  endfunction

  function automatic void check_field(input string name, input int unsigned want,
                                      input int unsigned got);
    if (want != got) begin
      error_count++;
      $display("%0t: %s mismatch, expected %0d actual %0d", $time, name, want, got);
    end
  endfunction

  always @(posedge clk) begin
    result_t want;
    if (rst_n && out_valid && !out_stall) begin
      if (pending_results.size() == 0) begin
        error_count++;
        $display("%0t: unexpected transaction, expected none actual status %0d",
                 $time, out_status);
      end else begin
        want = pending_results.pop_front();
        check_field("status", want.status, out_status);
        check_field("woken_valid", want.woken_valid, out_woken_valid);
        check_field("woken_thread", want.woken_thread, out_woken_thread);
        check_field("holder_valid", want.holder_valid, out_holder_valid);
        check_field("holder_thread", want.holder_thread, out_holder_thread);
        check_field("nest_depth", want.nest_depth, out_nest_depth);
      end
    end
  end

  initial begin
    out_stall <= 1'b0;
    forever begin
      @(posedge clk);
      if (!calm_tail && $urandom_range(0, 7) == 0) begin
        out_stall <= 1'b1;
        repeat ($urandom_range(1, 11)) @(posedge clk);
        out_stall <= 1'b0;
      end
    end
  end

  task automatic send_request(input op_t op, input logic [IN_TID_W-1:0] tid);
    if (!calm_tail && $urandom_range(0, 9) == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 11)) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_operation <= op;
    in_thread_id <= tid;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    pending_results.push_back(predict_lock(op, tid));
  endtask

  task automatic drain_results();
    in_valid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic test_single_owner();
    send_request(OP_ACQUIRE, 4'd0);
    send_request(OP_ACQUIRE, 4'd0);
    send_request(OP_RELEASE, 4'd0);
    send_request(OP_RELEASE, 4'd0);
    send_request(OP_RELEASE, 4'd0);
    send_request(OP_RELEASE, 4'd15);
    send_request(OP_ACQUIRE, 4'd15);
    send_request(OP_RELEASE, 4'd3);
    send_request(OP_RELEASE, 4'd15);
    drain_results();
  endtask

  task automatic test_waiters();
    send_request(OP_ACQUIRE, 4'd5);
    send_request(OP_ACQUIRE, 4'd9);
    send_request(OP_ACQUIRE, 4'd9);
    send_request(OP_ACQUIRE, 4'd12);
    send_request(OP_RELEASE, 4'd9);
    send_request(OP_RELEASE, 4'd5);
    send_request(OP_ACQUIRE, 4'd9);
    send_request(OP_RELEASE, 4'd9);
    send_request(OP_RELEASE, 4'd9);
    send_request(OP_ACQUIRE, 4'd5);
    send_request(OP_RELEASE, 4'd12);
    send_request(OP_RELEASE, 4'd5);
    drain_results();
  endtask

  task automatic test_nest_limit();
    repeat (2 ** NEST_BITS - 1) send_request(OP_ACQUIRE, 4'd10);
    send_request(OP_ACQUIRE, 4'd10);
    send_request(OP_ACQUIRE, 4'd6);
    repeat (2 ** NEST_BITS - 1) send_request(OP_RELEASE, 4'd10);
    send_request(OP_RELEASE, 4'd6);
    drain_results();
  endtask

  task automatic test_full_queue();
    send_request(OP_ACQUIRE, 4'd7);
    for (int k = 1; k < THREAD_COUNT; k++) begin
      send_request(OP_ACQUIRE, IN_TID_W'((7 + k) % THREAD_COUNT));
    end
    send_request(OP_ACQUIRE, 4'd3);
    while (lock_owned) send_request(OP_RELEASE, lock_owner);
    drain_results();
  endtask

  task automatic test_random_traffic(input int count);
    op_t                 op;
    logic [IN_TID_W-1:0] tid;
    int                  pick;
    for (int n = 0; n < count; n++) begin
      if (n == count - 20) calm_tail = 1'b1;
      if (n % 30 == 29) drain_results();
      pick = $urandom_range(0, 99);
      tid = IN_TID_W'($urandom_range(0, 15));
      if (pick < 35) begin
        op = OP_ACQUIRE;
      end else if (pick < 65) begin
        op = OP_RELEASE;
        if (lock_owned) tid = lock_owner;
      end else if (pick < 75) begin
        op = OP_ACQUIRE;
        if (lock_owned) tid = lock_owner;
      end else if (pick < 85) begin
        op = OP_ACQUIRE;
        if (ring_count > 0) begin
          tid = wait_ring[(ring_head + $urandom_range(0, ring_count - 1)) % THREAD_COUNT];
        end
      end else begin
        op = OP_RELEASE;
      end
      send_request(op, tid);
    end
    drain_results();
  endtask

  initial begin
    rst_n <= 1'b0;
    in_valid <= 1'b0;
    in_operation <= 1'b0;
    in_thread_id <= '0;
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;
    test_single_owner();
    test_waiters();
    test_nest_limit();
    test_full_queue();
    test_random_traffic(60);
    if (error_count == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule

### sim.f
hdl/mfw_pkg.sv
hdl/mfw_wait_queue.sv
hdl/mfw_lock_core.sv
hdl/recursive_mutex_fifo_waiters.sv
bench/tb.sv
